### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ordered array list engine.
// Uses clk_i and rst_ni of the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (!(prop))) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_NEVER(label, prop)
`endif
`endif

### rtl/oale_pkg.sv
// Package of the ordered array list engine: sizes, mode and status codes, states.
// No dependencies; used by the top level.
`default_nettype none

package oale_pkg;

  // Store size and derived widths.
  localparam int CAPACITY = 128;
  localparam int DATA_W   = 8;
  localparam int POS_W    = 8;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // Width for comparing positions against the element count without overflow.
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Request modes.
  typedef enum logic [2:0] {
    MODE_INSERT    = 3'd0,
    MODE_DELETE    = 3'd1,
    MODE_READ      = 3'd2,
    MODE_FIND      = 3'd3,
    MODE_DEL_VALUE = 3'd4,
    MODE_MAX       = 3'd5,
    MODE_CLEAR     = 3'd6
  } mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_POS   = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_TAIL,
    ST_PUT,
    ST_READ,
    ST_READ_WAIT,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### rtl/oale_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module oale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/ordered_array_list_engine.sv
// Top level of the ordered array list engine: request sequencer and element store.
// Depends on oale_pkg, oale_ram and assert_macros.svh.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | in_valid_i / in_ready_o | mode_i, position_i, value_i
//   out     | output    | out_valid_o/out_ready_i | status_o, value_out_o, position_out_o,
//           |           |                         | length_o, empty_res_o
//
// A single RAM with one read and one write port is walked one element per cycle:
// insert and delete move every element behind the position, find and max read up to
// the whole list, and delete by value first finds, then moves.
// in_ready_o is high only while the sequencer is idle; a finished result waits in the
// output register while the next item is accepted. Reset empties the list at once.

`default_nettype none
`include "assert_macros.svh"

module ordered_array_list_engine (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [2:0]                 mode_i,
  input  wire logic [7:0]                 position_i,
  input  wire logic signed [7:0]          value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [2:0]                      status_o,
  output logic signed [7:0]               value_out_o,
  output logic [7:0]                      position_out_o,
  output logic [7:0]                      length_o,
  output logic                            empty_res_o
);

  localparam int AW = oale_pkg::ADDR_W;
  localparam int CW = oale_pkg::CMP_W;
  localparam int NW = oale_pkg::CNT_W;
  localparam int PW = oale_pkg::POS_W;

  oale_pkg::state_e  state_q, state_d;
  oale_pkg::mode_e   mode_q, mode_d;
  oale_pkg::status_e status_q, status_d;

  logic signed [7:0] val_q, val_d;
  logic signed [7:0] vout_q, vout_d;
  logic [PW-1:0]     pout_q, pout_d;
  logic [NW-1:0]     count_q, count_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     tgt_q, tgt_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic              pend_q, pend_d;
  logic              cap_q, cap_d;
  logic              issued_q, issued_d;

  logic              ovalid_q, ovalid_d;
  oale_pkg::status_e ostatus_q, ostatus_d;
  logic signed [7:0] ovalue_q, ovalue_d;
  logic [PW-1:0]     opos_q, opos_d;
  logic [PW-1:0]     olen_q, olen_d;
  logic              oempty_q, oempty_d;

  logic              ram_we;
  logic [AW-1:0]     ram_wa;
  logic [7:0]        ram_wd;
  logic [AW-1:0]     ram_ra;
  logic [7:0]        ram_rd;

  logic [CW-1:0]     pos_c;
  logic [CW-1:0]     cnt_c;
  logic              ins_ok;
  logic              rng_ok;
  logic              is_full;
  logic              is_empty;
  logic              accept;
  logic              out_free;
  logic              match;
  logic              scan_last;
  logic [AW-1:0]     idx_in;
  logic [AW-1:0]     last_idx;
  logic [PW-1:0]     pidx_pos;
  oale_pkg::mode_e   mode_in;

  // Request decode against the current element count.
  assign mode_in   = oale_pkg::mode_e'(mode_i);
  assign pos_c     = CW'(position_i);
  assign cnt_c     = CW'(count_q);
  assign ins_ok    = (pos_c != '0) && (pos_c <= cnt_c + CW'(1));
  assign rng_ok    = (pos_c != '0) && (pos_c <= cnt_c);
  assign is_full   = (cnt_c >= CW'(oale_pkg::CAPACITY));
  assign is_empty  = (count_q == '0);
  assign idx_in    = AW'(pos_c - CW'(1));
  assign last_idx  = AW'(cnt_c - CW'(1));
  assign pidx_pos  = PW'(CW'(pidx_q) + CW'(1));
  assign match     = ($signed(ram_rd) == val_q);
  assign scan_last = (pidx_q == last_idx);

  assign in_ready_o = (state_q == oale_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !ovalid_q || out_ready_i;

  // Element store.
  oale_ram #(
    .WIDTH(oale_pkg::DATA_W),
    .DEPTH(oale_pkg::CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oale_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_in)
            oale_pkg::MODE_INSERT: begin
              if (is_full || !ins_ok) begin
                state_d = oale_pkg::ST_DONE;
              end else if (pos_c == cnt_c + CW'(1)) begin
                state_d = oale_pkg::ST_PUT;
              end else begin
                state_d = oale_pkg::ST_SHIFT_UP;
              end
            end
            oale_pkg::MODE_DELETE: begin
              state_d = rng_ok ? oale_pkg::ST_SHIFT_DN : oale_pkg::ST_DONE;
            end
            oale_pkg::MODE_READ: begin
              state_d = rng_ok ? oale_pkg::ST_READ : oale_pkg::ST_DONE;
            end
            oale_pkg::MODE_FIND, oale_pkg::MODE_DEL_VALUE, oale_pkg::MODE_MAX: begin
              state_d = is_empty ? oale_pkg::ST_DONE : oale_pkg::ST_SCAN;
            end
            default: begin
              state_d = oale_pkg::ST_DONE;
            end
          endcase
        end
      end
      oale_pkg::ST_SHIFT_UP: begin
        if (ptr_q == tgt_q) begin
          state_d = oale_pkg::ST_TAIL;
        end
      end
      oale_pkg::ST_SHIFT_DN: begin
        if (ptr_q == last_idx) begin
          state_d = oale_pkg::ST_TAIL;
        end
      end
      oale_pkg::ST_TAIL: begin
        state_d = (mode_q == oale_pkg::MODE_INSERT) ? oale_pkg::ST_PUT : oale_pkg::ST_DONE;
      end
      oale_pkg::ST_PUT: begin
        state_d = oale_pkg::ST_DONE;
      end
      oale_pkg::ST_READ: begin
        state_d = oale_pkg::ST_READ_WAIT;
      end
      oale_pkg::ST_READ_WAIT: begin
        state_d = oale_pkg::ST_DONE;
      end
      oale_pkg::ST_SCAN: begin
        if (pend_q) begin
          if (mode_q != oale_pkg::MODE_MAX && match) begin
            state_d = (mode_q == oale_pkg::MODE_DEL_VALUE) ?
                      oale_pkg::ST_SHIFT_DN : oale_pkg::ST_DONE;
          end else if (scan_last) begin
            state_d = oale_pkg::ST_DONE;
          end
        end
      end
      oale_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = oale_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = oale_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and store control for each state.
  always_comb begin
    mode_d    = mode_q;
    status_d  = status_q;
    val_d     = val_q;
    vout_d    = vout_q;
    pout_d    = pout_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    tgt_d     = tgt_q;
    wa_d      = wa_q;
    pidx_d    = pidx_q;
    pend_d    = 1'b0;
    cap_d     = 1'b0;
    issued_d  = issued_q;
    ovalid_d  = ovalid_q;
    ostatus_d = ostatus_q;
    ovalue_d  = ovalue_q;
    opos_d    = opos_q;
    olen_d    = olen_q;
    oempty_d  = oempty_q;
    ram_we    = 1'b0;
    ram_wa    = wa_q;
    ram_wd    = ram_rd;
    ram_ra    = ptr_q;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    // A pending shifted element lands in the cycle after its read; the first read
    // of a delete is the removed element itself.
    if (pend_q && (state_q == oale_pkg::ST_SHIFT_UP || state_q == oale_pkg::ST_SHIFT_DN ||
                   state_q == oale_pkg::ST_TAIL)) begin
      if (cap_q) begin
        vout_d = $signed(ram_rd);
      end else begin
        ram_we = 1'b1;
      end
    end

    unique case (state_q)
      oale_pkg::ST_IDLE: begin
        if (accept) begin
          mode_d   = mode_in;
          val_d    = value_i;
          status_d = oale_pkg::STATUS_OK;
          vout_d   = '0;
          pout_d   = '0;
          issued_d = 1'b0;
          unique case (mode_in)
            oale_pkg::MODE_INSERT: begin
              if (is_full) begin
                status_d = oale_pkg::STATUS_FULL;
              end else if (!ins_ok) begin
                status_d = oale_pkg::STATUS_BAD_POS;
              end else begin
                pout_d = position_i;
                tgt_d  = idx_in;
                ptr_d  = last_idx;
              end
            end
            oale_pkg::MODE_DELETE, oale_pkg::MODE_READ: begin
              if (!rng_ok) begin
                status_d = oale_pkg::STATUS_BAD_POS;
              end else begin
                pout_d = position_i;
                tgt_d  = idx_in;
                ptr_d  = idx_in;
              end
            end
            oale_pkg::MODE_FIND, oale_pkg::MODE_DEL_VALUE: begin
              ptr_d = '0;
              if (is_empty) begin
                status_d = oale_pkg::STATUS_NOT_FOUND;
              end
            end
            oale_pkg::MODE_MAX: begin
              ptr_d = '0;
              if (is_empty) begin
                status_d = oale_pkg::STATUS_EMPTY;
              end
            end
            oale_pkg::MODE_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // Walk down from the last element, each moved up by one place.
      oale_pkg::ST_SHIFT_UP: begin
        pend_d = 1'b1;
        wa_d   = ptr_q + AW'(1);
        if (ptr_q != tgt_q) begin
          ptr_d = ptr_q - AW'(1);
        end
      end
      // Walk up from the removed element, each later one moved down by one place.
      oale_pkg::ST_SHIFT_DN: begin
        pend_d = 1'b1;
        cap_d  = (ptr_q == tgt_q);
        wa_d   = ptr_q - AW'(1);
        if (ptr_q != last_idx) begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      oale_pkg::ST_TAIL: begin
        if (mode_q != oale_pkg::MODE_INSERT) begin
          count_d = count_q - NW'(1);
        end
      end
      oale_pkg::ST_PUT: begin
        ram_we  = 1'b1;
        ram_wa  = tgt_q;
        ram_wd  = val_q;
        count_d = count_q + NW'(1);
      end
      oale_pkg::ST_READ: begin
      end
      oale_pkg::ST_READ_WAIT: begin
        vout_d = $signed(ram_rd);
      end
      // Read one element per cycle and compare the one read in the cycle before.
      oale_pkg::ST_SCAN: begin
        if (!issued_q) begin
          pend_d = 1'b1;
          pidx_d = ptr_q;
          if (ptr_q == last_idx) begin
            issued_d = 1'b1;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
        if (pend_q) begin
          if (mode_q == oale_pkg::MODE_MAX) begin
            if (pidx_q == '0 || $signed(ram_rd) > vout_q) begin
              vout_d = $signed(ram_rd);
              pout_d = pidx_pos;
            end
          end else if (match) begin
            vout_d = $signed(ram_rd);
            pout_d = pidx_pos;
            tgt_d  = pidx_q;
            ptr_d  = pidx_q;
            pend_d = 1'b0;
          end else if (scan_last) begin
            status_d = oale_pkg::STATUS_NOT_FOUND;
          end
        end
      end
      oale_pkg::ST_DONE: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          ovalue_d  = vout_q;
          opos_d    = pout_q;
          olen_d    = PW'(count_q);
          oempty_d  = is_empty;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= oale_pkg::ST_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      cap_q    <= 1'b0;
      issued_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      cap_q    <= cap_d;
      issued_q <= issued_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    status_q  <= status_d;
    val_q     <= val_d;
    vout_q    <= vout_d;
    pout_q    <= pout_d;
    ptr_q     <= ptr_d;
    tgt_q     <= tgt_d;
    wa_q      <= wa_d;
    pidx_q    <= pidx_d;
    ostatus_q <= ostatus_d;
    ovalue_q  <= ovalue_d;
    opos_q    <= opos_d;
    olen_q    <= olen_d;
    oempty_q  <= oempty_d;
  end

  assign out_valid_o    = ovalid_q;
  assign status_o       = ostatus_q;
  assign value_out_o    = ovalue_q;
  assign position_out_o = opos_q;
  assign length_o       = olen_q;
  assign empty_res_o    = oempty_q;

  // The list never grows beyond the store.
  `ASSERT_ALWAYS(count_bound_a, count_q <= NW'(oale_pkg::CAPACITY))
  // The count moves by at most one per cycle, or drops to zero on clear.
  `ASSERT_ALWAYS(count_step_a, (count_q == '0) || (count_q - $past(count_q) + NW'(1) <= NW'(2)))
  // The scan never reads past the last element in use.
  `ASSERT_ALWAYS(scan_ptr_a, (state_q == oale_pkg::ST_SCAN && !issued_q) |-> (ptr_q <= last_idx))
  // The store is never written while the sequencer waits for an item.
  `ASSERT_NEVER(idle_write_a, ram_we && state_q == oale_pkg::ST_IDLE)

endmodule

`default_nettype wire
